FILE: rtl/jsu_pkg.sv
// jsu_pkg: shared types and character constants for the json string unescaper
// no dependencies; compiled first

package jsu_pkg;

    // parse state of the escape decoder; code 7 is unused and treated as normal
    typedef enum logic [2:0] {
        MODE_NORMAL = 3'd0,
        MODE_ESC    = 3'd1,
        MODE_U      = 3'd2,
        MODE_U0     = 3'd3,
        MODE_U00    = 3'd4,
        MODE_U002   = 3'd5,
        MODE_U003   = 3'd6
    } mode_t;

    localparam int RUN_MAX = 6;

    // character codes
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_2      = 8'h32;
    localparam logic [7:0] CH_3      = 8'h33;
    localparam logic [7:0] CH_7      = 8'h37;
    localparam logic [7:0] CH_LC_C   = 8'h63;
    localparam logic [7:0] CH_LC_E   = 8'h65;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_APOS   = 8'h27;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_BSP    = 8'h08;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_TAB    = 8'h09;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       string_end;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       run_last;
        logic       string_done;
    } out_item_t;

    // one decoded run: the results caused by one input beat
    typedef struct packed {
        logic [RUN_MAX-1:0][7:0] bytes;
        logic [2:0]              count;    // 1 .. RUN_MAX
        logic                    str_end;
        logic                    marker;   // end marker only, no character
    } run_t;

endpackage

FILE: rtl/jsu_stream_if.sv
// jsu_stream_if: valid/ready stream channel with a typed payload
// no dependencies; payload type set by the instantiating code

interface jsu_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (
        output valid,
        output data,
        input  ready
    );

    modport sink (
        input  valid,
        input  data,
        output ready
    );
endinterface

FILE: rtl/jsu_front.sv
// jsu_front: accepts input beats, tracks escape state, builds at most one run per beat
// depends on jsu_pkg and jsu_stream_if

module jsu_front (
    input  logic               clk,
    input  logic               rst_n,
    jsu_stream_if.sink         feed,
    output logic               push,
    output jsu_pkg::run_t      push_run,
    input  logic               full
);

    jsu_pkg::mode_t mode_reg;
    jsu_pkg::mode_t mode_next;
    jsu_pkg::mode_t mode_after;
    jsu_pkg::mode_t pmode;

    logic       accept;
    logic [7:0] c;
    logic       fin;
    logic       is_bs;
    logic       u_hit;
    logic       after_pending;
    logic [2:0] plen;
    logic [1:0] tlen;
    logic [7:0] tail0;
    logic [7:0] tail1;
    logic [2:0] total;

    function automatic logic [2:0] prefix_len(input jsu_pkg::mode_t m);
        case (m)
            jsu_pkg::MODE_U:    prefix_len = 3'd2;
            jsu_pkg::MODE_U0:   prefix_len = 3'd3;
            jsu_pkg::MODE_U00:  prefix_len = 3'd4;
            jsu_pkg::MODE_U002: prefix_len = 3'd5;
            jsu_pkg::MODE_U003: prefix_len = 3'd5;
            default:            prefix_len = 3'd0;
        endcase
    endfunction

    function automatic logic [7:0] prefix_char(input jsu_pkg::mode_t m, input logic [2:0] k);
        case (k)
            3'd0:    prefix_char = jsu_pkg::CH_BSLASH;
            3'd1:    prefix_char = jsu_pkg::CH_U;
            3'd2:    prefix_char = jsu_pkg::CH_0;
            3'd3:    prefix_char = jsu_pkg::CH_0;
            default: prefix_char = (m == jsu_pkg::MODE_U002) ? jsu_pkg::CH_2 : jsu_pkg::CH_3;
        endcase
    endfunction

    assign feed.ready = !full;
    assign accept     = feed.valid && !full;
    assign c          = feed.data.in_byte;
    assign fin        = feed.data.string_end;
    assign is_bs      = (c == jsu_pkg::CH_BSLASH);

    assign u_hit =
        ((mode_reg == jsu_pkg::MODE_U) && (c == jsu_pkg::CH_0))
        || ((mode_reg == jsu_pkg::MODE_U0) && (c == jsu_pkg::CH_0))
        || ((mode_reg == jsu_pkg::MODE_U00) && ((c == jsu_pkg::CH_2) || (c == jsu_pkg::CH_3)))
        || ((mode_reg == jsu_pkg::MODE_U002) && (c == jsu_pkg::CH_7))
        || ((mode_reg == jsu_pkg::MODE_U003)
            && ((c == jsu_pkg::CH_LC_C) || (c == jsu_pkg::CH_LC_E)));

    // next state
    always_comb
    begin
        case (mode_reg)
            jsu_pkg::MODE_ESC:
            begin
                mode_after = (c == jsu_pkg::CH_U) ? jsu_pkg::MODE_U : jsu_pkg::MODE_NORMAL;
            end
            jsu_pkg::MODE_U, jsu_pkg::MODE_U0, jsu_pkg::MODE_U00,
            jsu_pkg::MODE_U002, jsu_pkg::MODE_U003:
            begin
                if (!u_hit)
                begin
                    mode_after = is_bs ? jsu_pkg::MODE_ESC : jsu_pkg::MODE_NORMAL;
                end
                else if (mode_reg == jsu_pkg::MODE_U)
                begin
                    mode_after = jsu_pkg::MODE_U0;
                end
                else if (mode_reg == jsu_pkg::MODE_U0)
                begin
                    mode_after = jsu_pkg::MODE_U00;
                end
                else if (mode_reg == jsu_pkg::MODE_U00)
                begin
                    mode_after = (c == jsu_pkg::CH_2) ? jsu_pkg::MODE_U002 : jsu_pkg::MODE_U003;
                end
                else
                begin
                    mode_after = jsu_pkg::MODE_NORMAL;
                end
            end
            default:
            begin
                mode_after = is_bs ? jsu_pkg::MODE_ESC : jsu_pkg::MODE_NORMAL;
            end
        endcase
        mode_next = mode_reg;
        if (accept)
        begin
            mode_next = fin ? jsu_pkg::MODE_NORMAL : mode_after;
        end
    end

    assign after_pending = (mode_after == jsu_pkg::MODE_U) || (mode_after == jsu_pkg::MODE_U0)
        || (mode_after == jsu_pkg::MODE_U00) || (mode_after == jsu_pkg::MODE_U002)
        || (mode_after == jsu_pkg::MODE_U003);

    // run contents: literal \u prefix first, then up to two tail bytes
    always_comb
    begin
        pmode = jsu_pkg::MODE_NORMAL;
        tlen  = 2'd0;
        tail0 = 8'h00;
        tail1 = 8'h00;
        case (mode_reg)
            jsu_pkg::MODE_ESC:
            begin
                tlen = 2'd1;
                case (c)
                    jsu_pkg::CH_BSLASH: tail0 = jsu_pkg::CH_BSLASH;
                    jsu_pkg::CH_QUOTE:  tail0 = jsu_pkg::CH_QUOTE;
                    jsu_pkg::CH_B:      tail0 = jsu_pkg::CH_BSP;
                    jsu_pkg::CH_F:      tail0 = jsu_pkg::CH_FF;
                    jsu_pkg::CH_N:      tail0 = jsu_pkg::CH_LF;
                    jsu_pkg::CH_R:      tail0 = jsu_pkg::CH_CR;
                    jsu_pkg::CH_T:      tail0 = jsu_pkg::CH_TAB;
                    jsu_pkg::CH_U:      tlen  = 2'd0;
                    default:
                    begin
                        tlen  = 2'd2;
                        tail0 = jsu_pkg::CH_BSLASH;
                        tail1 = c;
                    end
                endcase
            end
            jsu_pkg::MODE_U, jsu_pkg::MODE_U0, jsu_pkg::MODE_U00,
            jsu_pkg::MODE_U002, jsu_pkg::MODE_U003:
            begin
                if (!u_hit)
                begin
                    // broken sequence: held prefix, then the byte as in normal mode
                    pmode = mode_reg;
                    if (!is_bs)
                    begin
                        tlen  = 2'd1;
                        tail0 = c;
                    end
                end
                else if (mode_reg == jsu_pkg::MODE_U002)
                begin
                    tlen  = 2'd1;
                    tail0 = jsu_pkg::CH_APOS;
                end
                else if (mode_reg == jsu_pkg::MODE_U003)
                begin
                    tlen  = 2'd1;
                    tail0 = (c == jsu_pkg::CH_LC_C) ? jsu_pkg::CH_LT : jsu_pkg::CH_GT;
                end
            end
            default:
            begin
                if (!is_bs)
                begin
                    tlen  = 2'd1;
                    tail0 = c;
                end
            end
        endcase
        // string ends inside a \u sequence: flush what is held
        if (fin && after_pending)
        begin
            pmode = mode_after;
        end
    end

    assign plen  = prefix_len(pmode);
    assign total = plen + {1'b0, tlen};

    always_comb
    begin
        for (int k = 0; k < jsu_pkg::RUN_MAX; k++)
        begin
            if (3'(k) < plen)
            begin
                push_run.bytes[k] = prefix_char(pmode, 3'(k));
            end
            else if (3'(k) == plen)
            begin
                push_run.bytes[k] = tail0;
            end
            else
            begin
                push_run.bytes[k] = tail1;
            end
        end
        push_run.marker  = (total == 3'd0);
        push_run.count   = (total == 3'd0) ? 3'd1 : total;
        push_run.str_end = fin;
    end

    assign push = accept && ((total != 3'd0) || fin);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= jsu_pkg::MODE_NORMAL;
        end
        else
        begin
            mode_reg <= mode_next;
        end
    end

endmodule

FILE: rtl/jsu_queue.sv
// jsu_queue: small fifo of decoded runs between front and back
// depends on jsu_pkg

module jsu_queue #(
    parameter int DEPTH = 2
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  jsu_pkg::run_t push_run,
    output logic          full,
    input  logic          pop,
    output jsu_pkg::run_t head_run,
    output logic          empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    jsu_pkg::run_t slot_reg [DEPTH];

    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] fill_reg, fill_next;

    function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] p);
        wrap_inc = (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    assign full     = (fill_reg == CW'(DEPTH));
    assign empty    = (fill_reg == '0);
    assign head_run = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wrap_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? wrap_inc(rd_ptr_reg) : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push && !pop)
        begin
            fill_next = fill_reg + CW'(1);
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_run;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

endmodule

FILE: rtl/jsu_back.sv
// jsu_back: walks the head run one byte per beat into the output register
// depends on jsu_pkg and jsu_stream_if

module jsu_back (
    input  logic          clk,
    input  logic          rst_n,
    input  jsu_pkg::run_t head_run,
    input  logic          empty,
    output logic          pop,
    jsu_stream_if.source  result
);

    logic               out_valid_reg, out_valid_next;
    jsu_pkg::out_item_t out_data_reg, out_data_next;
    logic [2:0]         idx_reg, idx_next;
    logic               load;
    logic               is_last;

    assign load    = !out_valid_reg || result.ready;
    assign is_last = ((idx_reg + 3'd1) == head_run.count);
    assign pop     = load && !empty && is_last;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        idx_next       = idx_reg;
        if (load)
        begin
            out_valid_next = !empty;
            if (!empty)
            begin
                out_data_next.out_byte    = head_run.bytes[idx_reg];
                out_data_next.byte_valid  = !head_run.marker;
                out_data_next.run_last    = is_last;
                out_data_next.string_done = is_last && head_run.str_end;
                idx_next = is_last ? 3'd0 : idx_reg + 3'd1;
            end
        end
    end

    assign result.valid = out_valid_reg;
    assign result.data  = out_data_reg;

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            idx_reg       <= 3'd0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            idx_reg       <= idx_next;
        end
    end

endmodule

FILE: rtl/json_string_unescaper_core.sv
// json_string_unescaper_core: top level of the json string unescaper
// depends on jsu_pkg, jsu_stream_if, jsu_front, jsu_queue and jsu_back

// Takes an escaped JSON string one byte per beat on feed and delivers the
// unescaped characters on result, one per beat. The escapes \\ \" \b \f \n
// \r \t map to their single character; \u0027, \u003c and \u003e (lowercase
// hex only) map to ', < and >; any other escape comes out as the backslash
// plus that character. A \u sequence is held until it matches or breaks;
// a broken or unterminated one comes out literally, and a lone backslash at
// the end of a string is dropped. Each input beat produces zero to six
// result beats; run_last marks the last beat caused by an input byte, and
// string_done marks the final beat of a string (a beat with byte_valid low
// carries only that end mark). Timing: the front decodes an input byte in
// the cycle it is accepted, so feed takes one byte per cycle while each byte
// yields at most one character and result is ready. The output register emits
// one beat per cycle while result is ready, so a byte that yields n beats
// holds the result side until all n are taken; the run queue (QUEUE_DEPTH
// runs) absorbs that, and feed backpressures once it fills.

module json_string_unescaper_core #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic         clk,
    input  logic         rst_n,
    jsu_stream_if.sink   feed,
    jsu_stream_if.source result
);

    // front to queue
    logic          q_push;
    jsu_pkg::run_t q_push_run;
    logic          q_full;

    // queue to back
    logic          q_pop;
    jsu_pkg::run_t q_head_run;
    logic          q_empty;

    // decode: escape state machine, at most one run per accepted byte
    jsu_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .feed     (feed),
        .push     (q_push),
        .push_run (q_push_run),
        .full     (q_full)
    );

    // decouples decode from the multi-beat drain
    jsu_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_run (q_push_run),
        .full     (q_full),
        .pop      (q_pop),
        .head_run (q_head_run),
        .empty    (q_empty)
    );

    // drain: one result beat per cycle from the head run while result is ready
    jsu_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head_run (q_head_run),
        .empty    (q_empty),
        .pop      (q_pop),
        .result   (result)
    );

`ifndef SYNTH
    // the front never writes into a full queue
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("run queue overflow");

    // the back never pops an empty queue
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("run queue underflow");

    // end of string always closes a run
    a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.data.string_done) |-> result.data.run_last)
        else $error("string_done without run_last");

    // an end-marker beat is a lone, final beat with a zero byte
    a_marker_form: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && !result.data.byte_valid)
        |-> (result.data.run_last && result.data.string_done
             && (result.data.out_byte == 8'h00)))
        else $error("malformed end marker");
`endif

endmodule
